// ===== rtl/glsu_pkg.sv =====
// Shared constants, payload types and control types of the gated linear state update block.
package glsu_pkg;

    localparam int HEAD_DIM   = 64;
    localparam int HEADS      = 4;
    localparam int BATCH      = 2;

    localparam int SLOTS      = BATCH * HEADS;
    localparam int DIM_W      = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MEM_AW     = SLOT_W + 2 * DIM_W;
    localparam int MEM_DEPTH  = 1 << MEM_AW;

    localparam int DECAY_REGS = 4;
    localparam int DECAY_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam logic [DECAY_W-1:0] DECAY_ONE = 17'd65536;

    localparam int ELEM_W     = 16;
    localparam int DATA_W     = 32;
    localparam int KV_W       = 2 * ELEM_W;
    localparam int DS_W       = DECAY_W + 1 + DATA_W;
    localparam int ACC_W      = DS_W + 1;
    localparam int KV_SHIFT   = 6;
    localparam int FRAC_W     = 16;
    localparam int QUOT_W     = ACC_W - FRAC_W;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic                     batch_index;
        logic [1:0]               head_index;
        logic [5:0]               row_index;
        logic [5:0]               col_index;
        logic signed [ELEM_W-1:0] key_element;
        logic signed [ELEM_W-1:0] value_element;
        logic                     last_element;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     update_done;
        logic                     saturated;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DRAIN,
        ST_READ
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OUT_LOAD,
        OUT_READ,
        OUT_UPDATE
    } out_sel_t;

    typedef struct packed {
        logic             accept;
        logic             issue;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             load_out;
        out_sel_t         out_sel;
    } cmd_t;

    typedef struct packed {
        logic slot_ok;
        logic busy;
    } status_t;

endpackage

// ===== rtl/glsu_req_if.sv =====
// Request channel interface: valid, ready and one request item.
interface glsu_req_if import glsu_pkg::*; ();

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/glsu_rsp_if.sv =====
// Response channel interface: valid, ready and one result item.
interface glsu_rsp_if import glsu_pkg::*; ();

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/glsu_ctrl.sv =====
// Controller: sequences loads, reads and the entry-by-entry state update sweep.
module glsu_ctrl import glsu_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    req_type,
    input  logic    last_element,
    input  logic    out_ready,
    input  status_t status,
    output logic    in_ready,
    output logic    out_valid,
    output cmd_t    cmd
);

    localparam logic [DIM_W-1:0] LAST_IDX = DIM_W'(HEAD_DIM - 1);

    ctrl_state_t      state_reg, state_next;
    logic [DIM_W-1:0] row_cnt_reg, row_cnt_next;
    logic [DIM_W-1:0] col_cnt_reg, col_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        cmd          = '0;
        cmd.out_sel  = OUT_LOAD;
        cmd.accept   = accept;
        cmd.row      = row_cnt_reg;
        cmd.col      = col_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (last_element && status.slot_ok)
                    begin
                        state_next   = ST_UPDATE;
                        row_cnt_next = '0;
                        col_cnt_next = '0;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OUT_LOAD;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.issue = 1'b1;
                if (col_cnt_reg == LAST_IDX)
                begin
                    col_cnt_next = '0;
                    row_cnt_next = row_cnt_reg + 1'b1;
                    if (row_cnt_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_UPDATE;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.load_out = 1'b1;
                cmd.out_sel  = OUT_READ;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== rtl/glsu_dp.sv =====
// Datapath: decay registers, key/value buffers, state memory and the shared multiply-accumulate.
module glsu_dp import glsu_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  cmd_t                 cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DECAY_W-1:0]   cfg_data,
    output status_t              status,
    output rsp_t                 rsp
);

    logic [DECAY_W-1:0]       decay_reg [DECAY_REGS];
    logic signed [ELEM_W-1:0] key_mem [HEAD_DIM];
    logic signed [ELEM_W-1:0] val_mem [HEAD_DIM];
    logic signed [DATA_W-1:0] state_mem [MEM_DEPTH];
    logic [SLOTS-1:0]         slot_valid_reg;

    logic [SLOT_W-1:0]        upd_slot_reg;
    logic [DECAY_W-1:0]       upd_decay_reg;
    logic                     upd_fresh_reg;
    logic                     rd_ok_reg;
    logic                     sat_flag_reg;

    logic signed [ELEM_W-1:0] key_rd_reg;
    logic signed [ELEM_W-1:0] val_rd_reg;
    logic signed [DATA_W-1:0] state_rd_reg;

    logic                     p1_valid_reg;
    logic [MEM_AW-1:0]        p1_addr_reg;
    logic                     p2_valid_reg;
    logic [MEM_AW-1:0]        p2_addr_reg;
    logic signed [KV_W-1:0]   kv_prod_reg;
    logic signed [DS_W-1:0]   ds_prod_reg;
    rsp_t                     rsp_reg;

    logic [SLOT_W-1:0]        req_slot;
    logic                     row_ok;
    logic                     col_ok;
    logic                     is_load;
    logic [MEM_AW-1:0]        upd_addr;
    logic [MEM_AW-1:0]        rd_addr;
    logic signed [DATA_W-1:0] old_val;
    logic signed [DECAY_W:0]  decay_s;
    logic signed [ACC_W-1:0]  acc;
    logic [QUOT_W-1:0]        acc_q;
    logic [QUOT_W-DATA_W:0]   acc_top;
    logic                     entry_sat;
    logic signed [DATA_W-1:0] entry_val;

    assign req_slot       = SLOT_W'(int'(req.batch_index) * HEADS + int'(req.head_index));
    assign status.slot_ok = (int'(req.batch_index) < BATCH) && (int'(req.head_index) < HEADS);
    assign status.busy    = p1_valid_reg || p2_valid_reg;
    assign row_ok         = int'(req.row_index) < HEAD_DIM;
    assign col_ok         = int'(req.col_index) < HEAD_DIM;
    assign is_load        = cmd.accept && (req.req_type == REQ_LOAD);

    assign upd_addr = {upd_slot_reg, cmd.row, cmd.col};
    assign rd_addr  = cmd.issue ? upd_addr
                                : {req_slot, DIM_W'(req.row_index), DIM_W'(req.col_index)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DECAY_REGS; i++)
            begin
                decay_reg[i] <= DECAY_ONE;
            end
        end
        else if (cfg_we && (int'(cfg_index) < DECAY_REGS))
        begin
            decay_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load && row_ok)
        begin
            key_mem[DIM_W'(req.row_index)] <= req.key_element;
            val_mem[DIM_W'(req.row_index)] <= req.value_element;
        end
        key_rd_reg <= key_mem[cmd.row];
        val_rd_reg <= val_mem[cmd.col];
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg)
        begin
            state_mem[p2_addr_reg] <= entry_val;
        end
        state_rd_reg <= state_mem[rd_addr];
    end

    // A slot reads as zero until its first update has rewritten every entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;
            if (cmd.load_out && (cmd.out_sel == OUT_UPDATE))
            begin
                slot_valid_reg[upd_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            upd_slot_reg  <= req_slot;
            upd_decay_reg <= decay_reg[req.head_index];
            upd_fresh_reg <= !slot_valid_reg[req_slot];
            rd_ok_reg     <= status.slot_ok && row_ok && col_ok && slot_valid_reg[req_slot];
            sat_flag_reg  <= 1'b0;
        end
        else if (p2_valid_reg && entry_sat)
        begin
            sat_flag_reg <= 1'b1;
        end
        p1_addr_reg <= upd_addr;
        p2_addr_reg <= p1_addr_reg;
        kv_prod_reg <= key_rd_reg * val_rd_reg;
        ds_prod_reg <= decay_s * old_val;
    end

    assign old_val = upd_fresh_reg ? '0 : state_rd_reg;
    assign decay_s = $signed({1'b0, upd_decay_reg});

    // The low fraction bits are dropped by an arithmetic shift, which floors.
    always_comb
    begin
        acc       = ACC_W'(ds_prod_reg) + ACC_W'($signed({kv_prod_reg, KV_SHIFT'(0)}));
        acc_q     = acc[ACC_W-1:FRAC_W];
        acc_top   = acc_q[QUOT_W-1:DATA_W-1];
        entry_sat = !((&acc_top) || !(|acc_top));
        if (!entry_sat)
        begin
            entry_val = $signed(acc_q[DATA_W-1:0]);
        end
        else if (acc_q[QUOT_W-1])
        begin
            entry_val = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            entry_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            unique case (cmd.out_sel)
                OUT_LOAD:
                begin
                    rsp_reg <= '0;
                end
                OUT_READ:
                begin
                    rsp_reg.read_data   <= rd_ok_reg ? state_rd_reg : '0;
                    rsp_reg.update_done <= 1'b0;
                    rsp_reg.saturated   <= 1'b0;
                end
                OUT_UPDATE:
                begin
                    rsp_reg.read_data   <= '0;
                    rsp_reg.update_done <= 1'b1;
                    rsp_reg.saturated   <= sat_flag_reg;
                end
                default:
                begin
                    rsp_reg <= '0;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/gated_linear_state_update.sv =====
// Top level of the gated linear attention recurrent state update block.
//
//   channel | direction | transfer content
//   req     | in        | load of one key/value element pair, or read of one state entry
//   rsp     | out       | read_data, update_done, saturated (one per request)
//   cfg     | in        | write of one per-head decay register, no read-back
//
// A load that does not finish a token is answered straight from the idle state; a read
// passes through the read state first. A load with last_element set sweeps the whole slot
// through the single shared multiply-accumulate, then waits in the drain state for it to empty.
// The state memory has one read and one write port; one entry passes per cycle.
// After reset all slots read as zero; no clearing pass is needed.
// A new request is taken only in the idle state, and only when no result waits
// or the waiting result transfers in the same cycle.
module gated_linear_state_update import glsu_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    glsu_req_if.sink             req,
    glsu_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DECAY_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    out_valid;
    rsp_t    rsp_data;

    glsu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .req_type     (req.data.req_type),
        .last_element (req.data.last_element),
        .out_ready    (rsp.ready),
        .status       (status),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .cmd          (cmd)
    );

    glsu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.data),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .rsp       (rsp_data)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign rsp.data  = rsp_data;

`ifndef SYNTHESIS
    a_ready_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !status.busy && !cmd.issue)
        else $error("request taken while the update sweep is active");

    a_read_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.data.req_type == REQ_READ)) |=> ##1 rsp.valid)
        else $error("read result not presented two cycles after the transfer");

    a_plain_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.data.req_type == REQ_LOAD)
            && !(req.data.last_element && status.slot_ok))
        |=> rsp.valid && !rsp.data.update_done && (rsp.data.read_data == '0))
        else $error("plain load did not produce an empty result in the next cycle");

    a_sat_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.saturated) |-> rsp.data.update_done)
        else $error("saturation reported on a result without an update");
`endif

endmodule

// ===== test/glsu_tb_pkg.sv =====
// Register names and the scoreboard class that mirrors the block's state and checks its results.
package glsu_tb_pkg;
    import glsu_pkg::*;

    localparam int SLOT_SIZE = HEAD_DIM * HEAD_DIM;
    localparam longint DATA_MAX = 64'sd2147483647;
    localparam longint DATA_MIN = -DATA_MAX - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        DECAY_HEAD_ZERO,
        DECAY_HEAD_ONE,
        DECAY_HEAD_TWO,
        DECAY_HEAD_THREE
    } decay_reg_t;

    class glsu_state_tracker;
        logic [DECAY_W-1:0]       decay_q [DECAY_REGS];
        logic signed [ELEM_W-1:0] key_q [HEAD_DIM];
        logic signed [ELEM_W-1:0] value_q [HEAD_DIM];
        int                       state_q [SLOTS*SLOT_SIZE];
        rsp_t                     pending_rsp [$];
        int                       error_count;
        int                       request_count;
        int                       update_count;
        int                       saturate_count;
        int                       read_count;

        function new();
            foreach (decay_q[i]) decay_q[i] = DECAY_ONE;
            foreach (key_q[i])
            begin
                key_q[i] = '0;
                value_q[i] = '0;
            end
            foreach (state_q[i]) state_q[i] = 0;
            error_count = 0;
            request_count = 0;
            update_count = 0;
            saturate_count = 0;
            read_count = 0;
        endfunction

        function void set_decay(decay_reg_t index, logic [DECAY_W-1:0] value);
            decay_q[index] = value;
        endfunction

        // Every entry of the slot becomes floor((decay*S + (k*v << 6)) / 2^16), clamped.
        function bit sweep_slot(int slot, logic [DECAY_W-1:0] decay);
            longint acc;
            longint quot;
            int     idx;
            bit     sat;
            sat = 1'b0;
            for (int r = 0; r < HEAD_DIM; r++)
            begin
                for (int c = 0; c < HEAD_DIM; c++)
                begin
                    idx = slot * SLOT_SIZE + r * HEAD_DIM + c;
                    acc = longint'(decay) * longint'(state_q[idx])
                        + ((longint'(key_q[r]) * longint'(value_q[c])) <<< KV_SHIFT);
                    quot = acc >>> FRAC_W;
                    if (quot > DATA_MAX)
                    begin
                        quot = DATA_MAX;
                        sat = 1'b1;
                    end
                    else if (quot < DATA_MIN)
                    begin
                        quot = DATA_MIN;
                        sat = 1'b1;
                    end
                    state_q[idx] = int'(quot);
                end
            end
            return sat;
        endfunction

        function void take_request(req_t rq);
            rsp_t exp_rsp;
            int   slot;
            bit   slot_ok;
            exp_rsp = '0;
            slot = int'(rq.batch_index) * HEADS + int'(rq.head_index);
            slot_ok = (int'(rq.batch_index) < BATCH) && (int'(rq.head_index) < HEADS);
            request_count++;
            if (rq.req_type == REQ_READ)
            begin
                read_count++;
                if (slot_ok)
                    exp_rsp.read_data = state_q[slot * SLOT_SIZE
                        + int'(rq.row_index) * HEAD_DIM + int'(rq.col_index)];
            end
            else
            begin
                key_q[rq.row_index] = rq.key_element;
                value_q[rq.row_index] = rq.value_element;
                if (rq.last_element && slot_ok)
                begin
                    exp_rsp.update_done = 1'b1;
                    exp_rsp.saturated = sweep_slot(slot, decay_q[rq.head_index]);
                    update_count++;
                    if (exp_rsp.saturated)
                        saturate_count++;
                end
            end
            pending_rsp.push_back(exp_rsp);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp_rsp;
            if (pending_rsp.size() == 0)
            begin
                $error("Result transfer arrived with no request outstanding.");
                error_count++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.read_data !== exp_rsp.read_data)
            begin
                $error("read_data mismatch: expected %0d, got %0d",
                       exp_rsp.read_data, got.read_data);
                error_count++;
            end
            if (got.update_done !== exp_rsp.update_done)
            begin
                $error("update_done mismatch: expected %0b, got %0b",
                       exp_rsp.update_done, got.update_done);
                error_count++;
            end
            if (got.saturated !== exp_rsp.saturated)
            begin
                $error("saturated mismatch: expected %0b, got %0b",
                       exp_rsp.saturated, got.saturated);
                error_count++;
            end
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction
    endclass

endpackage

// ===== test/tb_gated_linear_state_update.sv =====
// Testbench for the gated linear state update block: directed and random loads, updates and reads.
module tb_gated_linear_state_update;
    import glsu_pkg::*;
    import glsu_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DECAY_W-1:0]   cfg_data;

    glsu_req_if req_ch ();
    glsu_rsp_if rsp_ch ();

    glsu_state_tracker tracker;
    int                burst_left = 0;
    int                cycle_count = 0;
    int                settings_count = 0;
    logic              recent_batch = 1'b0;
    logic [1:0]        recent_head = 2'd0;

    gated_linear_state_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return ELEM_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [DECAY_W-1:0] rand_decay();
        case ($urandom_range(0, 4))
            0: return DECAY_ONE;
            1: return DECAY_W'($urandom_range(0, 131071));
            2: return DECAY_W'($urandom_range(0, 65535));
            3: return DECAY_W'($urandom_range(60000, 65535));
            default: return DECAY_W'($urandom_range(65537, 70000));
        endcase
    endfunction

    function automatic req_t make_load(logic b, logic [1:0] h, logic [5:0] row,
                                       logic signed [ELEM_W-1:0] key,
                                       logic signed [ELEM_W-1:0] val, logic fin);
        req_t rq;
        rq.req_type = REQ_LOAD;
        rq.batch_index = b;
        rq.head_index = h;
        rq.row_index = row;
        rq.col_index = 6'($urandom_range(0, 63));
        rq.key_element = key;
        rq.value_element = val;
        rq.last_element = fin;
        return rq;
    endfunction

    function automatic req_t make_read(logic b, logic [1:0] h, logic [5:0] row,
                                       logic [5:0] col);
        req_t rq;
        rq.req_type = REQ_READ;
        rq.batch_index = b;
        rq.head_index = h;
        rq.row_index = row;
        rq.col_index = col;
        rq.key_element = rand_elem();
        rq.value_element = rand_elem();
        rq.last_element = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    task automatic send_request(input req_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= item;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        tracker.take_request(item);
        burst_left--;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_decay(input decay_reg_t index, input logic [DECAY_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        tracker.set_decay(index, value);
    endtask

    task automatic program_decays(input logic [DECAY_W-1:0] d0, input logic [DECAY_W-1:0] d1,
                                  input logic [DECAY_W-1:0] d2, input logic [DECAY_W-1:0] d3);
        write_decay(DECAY_HEAD_ZERO, d0);
        write_decay(DECAY_HEAD_ONE, d1);
        write_decay(DECAY_HEAD_TWO, d2);
        write_decay(DECAY_HEAD_THREE, d3);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic run_reset_phase();
        logic signed [ELEM_W-1:0] key;
        logic signed [ELEM_W-1:0] val;
        send_request(make_read(1'b0, 2'd0, 6'd0, 6'd0));
        send_request(make_read(1'b1, 2'd3, 6'd63, 6'd63));
        for (int r = 0; r < HEAD_DIM; r++)
        begin
            key = rand_elem();
            val = rand_elem();
            if (r == 0)
            begin
                key = 16'sh7FFF;
                val = 16'sh7FFF;
            end
            else if (r == 1)
            begin
                key = 16'sh8000;
                val = 16'sh8000;
            end
            else if (r == 2)
            begin
                key = 16'sh7FFF;
                val = 16'sh8000;
            end
            send_request(make_load(1'b0, 2'd0, 6'(r), key, val, r == HEAD_DIM - 1));
        end
        send_request(make_read(1'b0, 2'd0, 6'd0, 6'd0));
        send_request(make_read(1'b0, 2'd0, 6'd1, 6'd1));
        send_request(make_read(1'b0, 2'd0, 6'd2, 6'd2));
        send_request(make_read(1'b0, 2'd0, 6'd63, 6'd63));
        send_request(make_load(1'b1, 2'd3, 6'd5, rand_elem(), rand_elem(), 1'b1));
        send_request(make_read(1'b1, 2'd3, 6'd5, 6'd5));
        send_request(make_read(1'b1, 2'd3, 6'd0, 6'd63));
        wait_idle();
    endtask

    // Head one runs with a decay near two, so repeated updates drive entries into both rails.
    task automatic run_extreme_phase();
        program_decays(17'd0, 17'd131071, DECAY_ONE, 17'd1);
        send_request(make_load(1'b0, 2'd0, 6'd0, 16'sh8000, 16'sh8000, 1'b1));
        send_request(make_read(1'b0, 2'd0, 6'd0, 6'd0));
        for (int i = 0; i < 14; i++)
        begin
            if (i % 2 == 0)
                send_request(make_load(1'b0, 2'd1, 6'd0, 16'sh8000, 16'sh8000, 1'b1));
            else
                send_request(make_load(1'b0, 2'd1, 6'd1, 16'sh7FFF, 16'sh7FFF, 1'b1));
        end
        send_request(make_read(1'b0, 2'd1, 6'd0, 6'd0));
        send_request(make_read(1'b0, 2'd1, 6'd1, 6'd0));
        send_request(make_read(1'b0, 2'd1, 6'd0, 6'd1));
        send_request(make_load(1'b1, 2'd3, 6'd2, rand_elem(), rand_elem(), 1'b1));
        send_request(make_load(1'b1, 2'd2, 6'd3, rand_elem(), rand_elem(), 1'b1));
        send_request(make_read(1'b1, 2'd3, 6'd5, 6'd5));
        send_request(make_read(1'b1, 2'd2, 6'd3, 6'd3));
        wait_idle();
    endtask

    task automatic run_random_phase(input int count);
        int         issued;
        int         choice;
        int         len;
        int         start;
        bit         in_order;
        logic       b;
        logic [1:0] h;
        logic [5:0] row;
        logic       fin;
        issued = 0;
        while (issued < count)
        begin
            choice = $urandom_range(0, 19);
            if (choice < 13)
            begin
                b = 1'($urandom_range(0, 1));
                h = 2'($urandom_range(0, 3));
                len = $urandom_range(1, 12);
                start = $urandom_range(0, HEAD_DIM - 1);
                in_order = 1'($urandom_range(0, 1));
                for (int j = 0; j < len; j++)
                begin
                    row = in_order ? 6'((start + j) % HEAD_DIM) : 6'($urandom_range(0, 63));
                    fin = (j == len - 1) && ($urandom_range(0, 3) == 0);
                    send_request(make_load(b, h, row, rand_elem(), rand_elem(), fin));
                    if (fin)
                    begin
                        recent_batch = b;
                        recent_head = h;
                    end
                    issued++;
                end
            end
            else if (choice < 18)
            begin
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(make_read(recent_batch, recent_head,
                                               6'($urandom_range(0, 63)),
                                               6'($urandom_range(0, 63))));
                    else
                        send_request(make_read(1'($urandom_range(0, 1)),
                                               2'($urandom_range(0, 3)),
                                               6'($urandom_range(0, 63)),
                                               6'($urandom_range(0, 63))));
                    issued++;
                end
            end
            else
            begin
                send_request(make_load(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                       6'($urandom_range(0, 63)), rand_elem(), rand_elem(),
                                       1'b0));
                issued++;
            end
        end
        wait_idle();
    endtask

    // The receiver stalls on its own pattern, with one long hold-off to back up the block.
    initial
    begin
        int results_seen;
        int hold_left;
        bit hold_done;
        int mode;
        int mode_left;
        int pattern_count;
        results_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        mode = 0;
        mode_left = 0;
        pattern_count = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                tracker.check_response(rsp_ch.data);
                results_seen++;
            end
            if (!hold_done && results_seen >= 400)
            begin
                hold_left = 600;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            pattern_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                rsp_ch.ready <= 1'b1;
            else if (mode == 1)
                rsp_ch.ready <= 1'($urandom_range(0, 1));
            else
                rsp_ch.ready <= (pattern_count % 7) < 4;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        tracker = new();
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_reset_phase();
        run_extreme_phase();
        for (int p = 0; p < 4; p++)
        begin
            program_decays(rand_decay(), rand_decay(), rand_decay(), rand_decay());
            run_random_phase(350);
        end
        repeat (20) @(posedge clk);
        $display("Run covered %0d request transfers: %0d loads and %0d entry reads.",
                 tracker.request_count, tracker.request_count - tracker.read_count,
                 tracker.read_count);
        $display("It made %0d state updates, %0d of them saturating, over %0d decay settings.",
                 tracker.update_count, tracker.saturate_count, settings_count);
        if (tracker.error_count == 0 && tracker.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
